// ----- rtl/idb_pkg.sv -----
// ----------------------------------------------------------------------------
// idb_pkg - shared types and codes of the indexed deque buffer
// Operation and status codes, channel field widths and the control word
// broadcast from the decoder to every storage cell.
// ----------------------------------------------------------------------------
package idb_pkg;

    localparam int MODE_W   = 4;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam int IDX_W    = 11;
    localparam int MAX_DW   = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD_BACK   = 4'd0,
        MODE_ADD_FRONT  = 4'd1,
        MODE_TAKE_BACK  = 4'd2,
        MODE_TAKE_FRONT = 4'd3,
        MODE_INSERT     = 4'd4,
        MODE_ERASE      = 4'd5,
        MODE_READ       = 4'd6,
        MODE_WRITE      = 4'd7,
        MODE_CLEAR      = 4'd8,
        MODE_RESIZE     = 4'd9
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MV_HOLD = 2'd0,
        MV_UP   = 2'd1,
        MV_DOWN = 2'd2
    } t_move;

    typedef struct packed {
        t_move              mv;
        logic [IDX_W-1:0]   lo;
        logic [IDX_W-1:0]   hi;
        logic [MAX_DW-1:0]  value;
    } t_cell_ctl;

endpackage

// ----- rtl/idb_if.sv -----
// ----------------------------------------------------------------------------
// idb_if - item channels of the indexed deque buffer
// Valid/ready channels for operation items in and result items out.
// ----------------------------------------------------------------------------
interface idb_in_if;
    import idb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface idb_out_if;
    import idb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]         count;
    logic signed [VALUE_W-1:0]  front_value;
    logic signed [VALUE_W-1:0]  back_value;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, output read_value, output count, output front_value,
                    output back_value, output status, input ready);
    modport sink   (input valid, input read_value, input count, input front_value,
                    input back_value, input status, output ready);
endinterface

// ----- rtl/idb_cell.sv -----
// ----------------------------------------------------------------------------
// idb_cell - one storage place of the indexed deque buffer
// Holds one word; loads the broadcast value, takes a neighbour's word or
// holds, as selected by the control word and its own index.
// ----------------------------------------------------------------------------
module idb_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                   i_clk,
    input  idb_pkg::t_cell_ctl     i_ctl,
    input  logic [DATA_WIDTH-1:0]  i_left,
    input  logic [DATA_WIDTH-1:0]  i_right,
    output logic [DATA_WIDTH-1:0]  o_word
);
    import idb_pkg::*;

    localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (CELL_IDX >= i_ctl.lo && CELL_IDX < i_ctl.hi) begin
            n_word = i_ctl.value[DATA_WIDTH-1:0];
        end else if (i_ctl.mv == MV_UP && CELL_IDX >= i_ctl.hi) begin
            n_word = i_left;
        end else if (i_ctl.mv == MV_DOWN && CELL_IDX >= i_ctl.lo) begin
            n_word = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ----- rtl/indexed_deque_buffer_top.sv -----
// Latency: a result item is offered in the cycle after its operation item is taken.
// Throughput: one item per cycle; all cells shift or load together at the same edge.
// The ready signal drops only while a result item waits and the sink is stalled.
// Reset clears the length and the result valid; cell contents are not cleared.
// ----------------------------------------------------------------------------
// indexed_deque_buffer_top - indexed double-ended buffer
// Decodes each operation, broadcasts a shift/load control word along a chain
// of storage cells and returns the read, count, front, back and status.
// ----------------------------------------------------------------------------
module indexed_deque_buffer_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    idb_in_if.sink     i_in,
    idb_out_if.source  o_out
);
    import idb_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int W  = (LW > POS_W) ? LW : POS_W;

    logic [LW-1:0]              r_len;
    logic [LW-1:0]              n_len;
    logic                       r_valid;
    logic signed [VALUE_W-1:0]  r_read_value;
    logic signed [VALUE_W-1:0]  n_read_value;
    t_status                    r_status;
    t_status                    n_status;
    t_cell_ctl                  w_ctl;
    logic                       w_accept;
    logic [W-1:0]               w_len;
    logic [W-1:0]               w_pos;
    logic [DATA_WIDTH-1:0]      w_word [DEPTH];
    logic [DATA_WIDTH-1:0]      w_rd_word;
    logic [DATA_WIDTH-1:0]      w_back_word;

    assign w_len    = W'(r_len);
    assign w_pos    = W'(i_in.position);
    assign w_accept = i_in.valid && i_in.ready;

    assign i_in.ready = !r_valid || o_out.ready;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_word[g+1];
        end
        idb_cell #(
            .INDEX      (g),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_word[g])
        );
    end

    assign w_rd_word   = w_word[w_pos[IW-1:0]];
    assign w_back_word = w_word[IW'(r_len - 1'b1)];

    always_comb begin
        n_len        = r_len;
        n_status     = ST_OK;
        n_read_value = '0;
        w_ctl.mv     = MV_HOLD;
        w_ctl.lo     = '0;
        w_ctl.hi     = '0;
        w_ctl.value  = MAX_DW'($signed(i_in.value));
        unique case (i_in.mode)
            MODE_ADD_BACK: begin
                if (w_len >= W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.lo = IDX_W'(w_len);
                    w_ctl.hi = IDX_W'(w_len + 1'b1);
                    n_len    = LW'(w_len + 1'b1);
                end
            end
            MODE_ADD_FRONT: begin
                if (w_len >= W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.mv = MV_UP;
                    w_ctl.hi = IDX_W'(1);
                    n_len    = LW'(w_len + 1'b1);
                end
            end
            MODE_TAKE_BACK: begin
                if (r_len == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_len = r_len - 1'b1;
                end
            end
            MODE_TAKE_FRONT: begin
                if (r_len == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctl.mv = MV_DOWN;
                    n_len    = r_len - 1'b1;
                end
            end
            MODE_INSERT: begin
                if (w_pos > w_len) begin
                    n_status = ST_RANGE;
                end else if (w_len >= W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.mv = MV_UP;
                    w_ctl.lo = IDX_W'(w_pos);
                    w_ctl.hi = IDX_W'(w_pos + 1'b1);
                    n_len    = LW'(w_len + 1'b1);
                end
            end
            MODE_ERASE: begin
                if (w_pos >= w_len) begin
                    n_status = ST_RANGE;
                end else begin
                    w_ctl.mv = MV_DOWN;
                    w_ctl.lo = IDX_W'(w_pos);
                    w_ctl.hi = IDX_W'(w_pos);
                    n_len    = r_len - 1'b1;
                end
            end
            MODE_READ: begin
                if (w_pos >= w_len) begin
                    n_status = ST_RANGE;
                end else begin
                    n_read_value = VALUE_W'($signed(w_rd_word));
                end
            end
            MODE_WRITE: begin
                if (w_pos >= w_len) begin
                    n_status = ST_RANGE;
                end else begin
                    w_ctl.lo = IDX_W'(w_pos);
                    w_ctl.hi = IDX_W'(w_pos + 1'b1);
                end
            end
            MODE_CLEAR: begin
                n_len = '0;
            end
            MODE_RESIZE: begin
                if (w_pos > W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.lo = IDX_W'(w_len);
                    w_ctl.hi = IDX_W'(w_pos);
                    n_len    = LW'(w_pos);
                end
            end
            default: begin
            end
        endcase
        if (!w_accept) begin
            w_ctl.mv = MV_HOLD;
            w_ctl.lo = '0;
            w_ctl.hi = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_len   <= n_len;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.read_value  = r_read_value;
    assign o_out.status      = r_status;
    assign o_out.count       = w_len[COUNT_W-1:0];
    assign o_out.front_value = (r_len != '0) ? VALUE_W'($signed(w_word[0])) : '0;
    assign o_out.back_value  = (r_len != '0) ? VALUE_W'($signed(w_back_word)) : '0;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_len <= W'(DEPTH))
        else $error("length beyond depth");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && n_status != ST_OK |=> r_len == $past(r_len) && r_status != ST_OK)
        else $error("rejected item changed length");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in.mode == MODE_CLEAR |=> r_len == '0 && o_out.front_value == '0)
        else $error("clear left entries");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_in.mode == MODE_ADD_BACK || i_in.mode == MODE_ADD_FRONT)
            && w_len < W'(DEPTH)
        |=> r_len == LW'($past(r_len) + 1'b1))
        else $error("push did not grow length");

endmodule
